[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, reset-qualified on an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define KVAT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle.
`define KVAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/kvat_pkg.sv]
// ----------------------------------------------------------------------------
// kvat_pkg
// Token kinds, character codes and byte classes of the key=value tokenizer.
// ----------------------------------------------------------------------------
package kvat_pkg;

  typedef enum logic [2:0] {
    KIND_KEY      = 3'd0,
    KIND_VALUE    = 3'd1,
    KIND_PAIR_END = 3'd2,
    KIND_END_OK   = 3'd3,
    KIND_END_ERR  = 3'd4
  } token_kind_e;

  localparam logic [7:0] CharEquals = 8'h3D;
  localparam logic [7:0] CharSquote = 8'h27;
  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;

  // Results one input word can cause: a byte token, a pair end, a final end.
  localparam int unsigned MaxResults = 3;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

endpackage

[rtl/key_value_arg_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// key_value_arg_tokenizer_core
// Output: the first result of an input word is shown in the cycle after accept.
// Throughput: one word per cycle while the result port does not stall and each
// word yields at most one result; else the input waits for the last result.
// Reset: asynchronous, active low; parser returns to between pairs, no error.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_value_arg_tokenizer_core import kvat_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input word channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_string_i,
  // result word channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] token_byte_o,
  output logic       run_last_o
);

  // Parser mode, carried from one input word to the next.
  typedef enum logic [2:0] {
    MODE_BETWEEN  = 3'd0,
    MODE_KEY      = 3'd1,
    MODE_AFTER_EQ = 3'd2,
    MODE_BARE     = 3'd3,
    MODE_DQUOTE   = 3'd4,
    MODE_SQUOTE   = 3'd5
  } mode_e;

  mode_e mode_q, mode_d;
  logic  err_q, err_d;

  // Result group: the results of one input word, slot 0 shown on the port.
  // A result word taken with no new word accepted shifts the group down by one.
  token_kind_e grp_kind_q [MaxResults];
  token_kind_e grp_kind_d [MaxResults];
  logic [7:0]  grp_byte_q [MaxResults];
  logic [7:0]  grp_byte_d [MaxResults];
  logic [1:0]  grp_cnt_q, grp_cnt_d;

  // Results computed for the word on the input port.
  token_kind_e new_kind [MaxResults];
  logic [7:0]  new_byte [MaxResults];
  logic [1:0]  new_cnt;

  logic in_acc, out_take;

  // Accept a new word when the group is empty or its last result leaves now.
  assign in_stall_o = (grp_cnt_q > 2'd1) || ((grp_cnt_q == 2'd1) && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o  = (grp_cnt_q != 2'd0);
  assign out_take     = out_valid_o && !out_stall_i;
  assign token_kind_o = grp_kind_q[0];
  assign token_byte_o = grp_byte_q[0];
  assign run_last_o   = (grp_cnt_q == 2'd1);

  // --------------------------------------------------------------------------
  // Parse step: byte handling first, then the end-of-string rule. Results
  // are packed into the new group in order; new_cnt counts them.
  // --------------------------------------------------------------------------
  always_comb begin
    mode_d  = mode_q;
    err_d   = err_q;
    new_cnt = 2'd0;
    for (int i = 0; i < MaxResults; i++) begin
      new_kind[i] = KIND_END_OK;
      new_byte[i] = 8'h00;
    end

    // A sticky error swallows every byte of the string.
    if (!err_q) begin
      unique case (mode_q)
        MODE_KEY: begin
          if (char_in_i == CharEquals) begin
            mode_d = MODE_AFTER_EQ;
          end else begin
            new_kind[new_cnt] = KIND_KEY;
            new_byte[new_cnt] = char_in_i;
            new_cnt           = new_cnt + 2'd1;
          end
        end
        MODE_AFTER_EQ: begin
          if (char_in_i == CharSquote) begin
            mode_d = MODE_SQUOTE;
          end else if (char_in_i == CharDquote) begin
            mode_d = MODE_DQUOTE;
          end else if (is_ws(char_in_i)) begin
            // Whitespace right after '=' closes an empty value.
            new_kind[new_cnt] = KIND_PAIR_END;
            new_cnt           = new_cnt + 2'd1;
            mode_d            = MODE_BETWEEN;
          end else begin
            new_kind[new_cnt] = KIND_VALUE;
            new_byte[new_cnt] = char_in_i;
            new_cnt           = new_cnt + 2'd1;
            mode_d            = MODE_BARE;
          end
        end
        MODE_BARE: begin
          if (is_ws(char_in_i)) begin
            new_kind[new_cnt] = KIND_PAIR_END;
            new_cnt           = new_cnt + 2'd1;
            mode_d            = MODE_BETWEEN;
          end else begin
            new_kind[new_cnt] = KIND_VALUE;
            new_byte[new_cnt] = char_in_i;
            new_cnt           = new_cnt + 2'd1;
          end
        end
        MODE_DQUOTE, MODE_SQUOTE: begin
          // Closing quote matches the opening one; the quote is not emitted.
          if ((mode_q == MODE_DQUOTE && char_in_i == CharDquote) ||
              (mode_q == MODE_SQUOTE && char_in_i == CharSquote)) begin
            new_kind[new_cnt] = KIND_PAIR_END;
            new_cnt           = new_cnt + 2'd1;
            mode_d            = MODE_BETWEEN;
          end else begin
            new_kind[new_cnt] = KIND_VALUE;
            new_byte[new_cnt] = char_in_i;
            new_cnt           = new_cnt + 2'd1;
          end
        end
        default: begin
          // Between pairs; unused mode codes behave the same way.
          if (char_in_i == CharEquals) begin
            err_d = 1'b1;
          end else if (!is_ws(char_in_i)) begin
            new_kind[new_cnt] = KIND_KEY;
            new_byte[new_cnt] = char_in_i;
            new_cnt           = new_cnt + 2'd1;
            mode_d            = MODE_KEY;
          end else begin
            mode_d = MODE_BETWEEN;
          end
        end
      endcase
    end

    // End rule: close an open bare or empty value, flag an open key or quote.
    if (end_of_string_i) begin
      if (!err_d) begin
        if (mode_d == MODE_AFTER_EQ || mode_d == MODE_BARE) begin
          new_kind[new_cnt] = KIND_PAIR_END;
          new_cnt           = new_cnt + 2'd1;
        end else if (mode_d == MODE_KEY || mode_d == MODE_DQUOTE ||
                     mode_d == MODE_SQUOTE) begin
          err_d = 1'b1;
        end
      end
      new_kind[new_cnt] = err_d ? KIND_END_ERR : KIND_END_OK;
      new_cnt           = new_cnt + 2'd1;
      mode_d            = MODE_BETWEEN;
      err_d             = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result group next value: load on accept, else shift on take.
  // --------------------------------------------------------------------------
  always_comb begin
    grp_cnt_d = grp_cnt_q;
    for (int i = 0; i < MaxResults; i++) begin
      grp_kind_d[i] = grp_kind_q[i];
      grp_byte_d[i] = grp_byte_q[i];
    end
    if (in_acc) begin
      grp_cnt_d = new_cnt;
      for (int i = 0; i < MaxResults; i++) begin
        grp_kind_d[i] = new_kind[i];
        grp_byte_d[i] = new_byte[i];
      end
    end else if (out_take) begin
      grp_cnt_d = grp_cnt_q - 2'd1;
      for (int i = 0; i < MaxResults - 1; i++) begin
        grp_kind_d[i] = grp_kind_q[i + 1];
        grp_byte_d[i] = grp_byte_q[i + 1];
      end
    end
  end

  // Control state, reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_BETWEEN;
      err_q     <= 1'b0;
      grp_cnt_q <= 2'd0;
    end else begin
      grp_cnt_q <= grp_cnt_d;
      if (in_acc) begin
        mode_q <= mode_d;
        err_q  <= err_d;
      end
    end
  end

  // Result payload, no reset.
  always_ff @(posedge clk_i) begin
    grp_kind_q <= grp_kind_d;
    grp_byte_q <= grp_byte_d;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `KVAT_ASSERT_IMPL(a_end_is_last, clk_i, rst_ni,
    out_valid_o && (token_kind_o == KIND_END_OK || token_kind_o == KIND_END_ERR),
    run_last_o, "end token is not the last result of its word")
  `KVAT_ASSERT_IMPL(a_mark_byte_zero, clk_i, rst_ni,
    out_valid_o && (token_kind_o == KIND_PAIR_END || token_kind_o == KIND_END_OK ||
                    token_kind_o == KIND_END_ERR),
    token_byte_o == 8'h00, "marker token carries a nonzero byte")
  `KVAT_ASSERT_NEXT(a_end_resets, clk_i, rst_ni,
    in_acc && end_of_string_i,
    (mode_q == MODE_BETWEEN) && !err_q && out_valid_o,
    "parser not back to reset state after end of string")

endmodule
